// ===== hw/rtl/oets_pkg.sv =====
// ----------------------------------------------------------------------------
// oets_pkg: shared types and constants for the odd-even transposition sorter
// Holds the key width, the store size and the transfer and control structs.
// ----------------------------------------------------------------------------
package oets_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key_value;
    logic                       final_key;
  } key_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] sorted_value;
    logic                       final_out;
    logic                       overflowed;
  } res_t;

  typedef struct packed {
    logic load;
    logic sort;
    logic odd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             last;
  } sts_t;

endpackage

// ===== hw/rtl/oets_datapath.sv =====
// ----------------------------------------------------------------------------
// oets_datapath: key cells with parallel compare-exchange
// Loads keys into a row of cells, runs one transposition phase per sort
// command, and shifts the row down one cell per emitted result.
// ----------------------------------------------------------------------------
module oets_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  oets_pkg::cmd_t           cmd,
  input  logic signed [oets_pkg::KEY_BITS-1:0] key_value,
  output oets_pkg::sts_t           sts,
  output oets_pkg::res_t           res_data
);

  logic signed [oets_pkg::KEY_BITS-1:0] cells      [oets_pkg::CAPACITY];
  logic signed [oets_pkg::KEY_BITS-1:0] cells_next [oets_pkg::CAPACITY];
  logic [oets_pkg::CNT_W-1:0] count;
  logic [oets_pkg::CNT_W-1:0] count_next;
  logic lost;
  logic lost_next;
  logic full;

  assign full = (count == oets_pkg::CNT_W'(oets_pkg::CAPACITY));

  always_comb begin
    cells_next = cells;
    count_next = count;
    lost_next  = lost;
    if (cmd.load) begin
      if (full) begin
        lost_next = 1'b1;
      end else begin
        count_next = count + 1'b1;
      end
    end
    for (int i = 0; i < oets_pkg::CAPACITY; i++) begin
      if (cmd.load && !full && (oets_pkg::CNT_W'(i) == count)) begin
        cells_next[i] = key_value;
      end
    end
    for (int i = 0; i < oets_pkg::CAPACITY - 1; i++) begin
      if (cmd.sort && ((i % 2) == int'(cmd.odd)) &&
          (oets_pkg::CNT_W'(i + 1) < count) && (cells[i] > cells[i+1])) begin
        cells_next[i]   = cells[i+1];
        cells_next[i+1] = cells[i];
      end
    end
    if (cmd.emit) begin
      for (int i = 0; i < oets_pkg::CAPACITY - 1; i++) begin
        cells_next[i] = cells[i+1];
      end
      count_next = count - 1'b1;
      if (count == oets_pkg::CNT_W'(1)) begin
        lost_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      lost  <= 1'b0;
    end else begin
      count <= count_next;
      lost  <= lost_next;
    end
  end

  assign sts.count = count;
  assign sts.last  = (count == oets_pkg::CNT_W'(1));

  assign res_data.sorted_value = cells[0];
  assign res_data.final_out    = sts.last;
  assign res_data.overflowed   = lost;

endmodule

// ===== hw/rtl/oets_ctrl.sv =====
// ----------------------------------------------------------------------------
// oets_ctrl: load / sort / emit sequencer
// Steps through loading, one phase per cycle while sorting, and emitting.
// ----------------------------------------------------------------------------
module oets_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           key_valid,
  input  logic           final_key,
  input  logic           res_stall,
  input  oets_pkg::sts_t sts,
  output oets_pkg::cmd_t cmd,
  output logic           key_stall,
  output logic           res_valid
);

  logic [1:0] state;
  logic [1:0] state_next;
  logic [oets_pkg::CNT_W-1:0] phase;
  logic [oets_pkg::CNT_W-1:0] phase_next;

  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      oets_pkg::S_LOAD: begin
        if (key_valid && final_key) begin
          state_next = oets_pkg::S_SORT;
          phase_next = '0;
        end
      end
      oets_pkg::S_SORT: begin
        if (phase == sts.count - 1'b1) begin
          state_next = oets_pkg::S_EMIT;
          phase_next = '0;
        end else begin
          phase_next = phase + 1'b1;
        end
      end
      oets_pkg::S_EMIT: begin
        if (!res_stall && sts.last) begin
          state_next = oets_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = oets_pkg::S_LOAD;
        phase_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oets_pkg::S_LOAD;
      phase <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign key_stall = (state != oets_pkg::S_LOAD);
  assign res_valid = (state == oets_pkg::S_EMIT);

  assign cmd.load = (state == oets_pkg::S_LOAD) && key_valid;
  assign cmd.sort = (state == oets_pkg::S_SORT);
  assign cmd.odd  = phase[0];
  assign cmd.emit = (state == oets_pkg::S_EMIT) && !res_stall;

endmodule

// ===== hw/rtl/odd_even_transposition_sorter.sv =====
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter: collects signed keys and returns them sorted
//
//   channel   dir  handshake            payload
//   key       in   key_valid/key_stall  key_data  (key_value, final_key)
//   res       out  res_valid/res_stall  res_data  (sorted_value, final_out,
//                                                  overflowed)
//
// Loading accepts every key transfer, dropped keys included. With N
// kept keys (at most 64) the set is then sorted in N transposition
// phases (one transposition phase per cycle, all pairs at once) and
// emitted one result per transfer, pausing while the result side stalls.
// key_stall is high while sorting and emitting. Keys past 64 are dropped
// and flagged on every result of the set.
// Synchronous reset returns to loading with an empty set.
// ----------------------------------------------------------------------------
module odd_even_transposition_sorter (
  input  logic           clk,
  input  logic           rst,
  input  logic           key_valid,
  output logic           key_stall,
  input  oets_pkg::key_t key_data,
  output logic           res_valid,
  input  logic           res_stall,
  output oets_pkg::res_t res_data
);

  oets_pkg::cmd_t cmd;
  oets_pkg::sts_t sts;

  oets_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .final_key (key_data.final_key),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd       (cmd),
    .key_stall (key_stall),
    .res_valid (res_valid)
  );

  oets_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .key_value (key_data.key_value),
    .sts       (sts),
    .res_data  (res_data)
  );

endmodule

// ===== hw/rtl/oets_checker.sv =====
// ----------------------------------------------------------------------------
// oets_checker: port-level checks for the sorter
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module oets_checker (
  input logic           clk,
  input logic           rst,
  input logic           key_valid,
  input logic           key_stall,
  input oets_pkg::key_t key_data,
  input logic           res_valid,
  input logic           res_stall,
  input oets_pkg::res_t res_data
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // no key is taken while results are out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && !key_stall))
    else $error("key accepted during emit");

  // last key of a set closes the input
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_stall && key_data.final_key |=> key_stall)
    else $error("input open after final key");

  // run ends after the final result
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && res_data.final_out |=> !res_valid && !key_stall)
    else $error("results continue after final");

endmodule

bind odd_even_transposition_sorter oets_checker u_oets_checker (.*);
